@@ rtl/linear_key_value_table_top_assert.svh @@
// Assertion macros for the linear key-value table.
// Used by linear_key_value_table_top; no other dependencies.
`ifndef LINEAR_KEY_VALUE_TABLE_TOP_ASSERT_SVH
`define LINEAR_KEY_VALUE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LKVT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lkvt assertion failed");

// Next-cycle implication, checked outside reset.
`define LKVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lkvt assertion failed");

`endif

@@ rtl/lkvt_pkg.sv @@
// Shared types and constants of the linear key-value table.
// No dependencies; used by every other file of the block but the assertion header.
package lkvt_pkg;

	localparam int CAPACITY = 16;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int CMD_W    = 2;
	localparam int STAT_W   = 3;
	localparam int ENTRY_W  = 5;

	// Command codes; bit 1 set means lookup
	localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;

	typedef enum logic [STAT_W-1:0] {
		ST_UPDATED   = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_DELETED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4,
		ST_FOUND     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_CMP,
		S_SHRD,
		S_SHWR,
		S_FIN
	} state_t;

	// Memory address source
	typedef enum logic [1:0] {
		ADDR_IDX,
		ADDR_NEXT,
		ADDR_FILL
	} addr_sel_t;

	typedef struct packed {
		logic [KEY_W-1:0]        key;
		logic signed [VAL_W-1:0] value;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic      in_ready;
		logic      idx_inc;
		logic      rd_en;
		logic      wr_en;
		addr_sel_t addr_sel;
		logic      wd_from_rd;
		logic      fill_inc;
		logic      fill_dec;
		logic      res_load;
		status_t   res_status;
		logic      res_found;
		logic      out_load;
	} ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic             in_valid;
		logic [CMD_W-1:0] cmd;
		logic             match;
		logic             idx_end;
		logic             shift_end;
		logic             full;
		logic             out_free;
	} sts_t;

endpackage

@@ rtl/lkvt_req_if.sv @@
// Request channel: command, key and value with valid/ready.
// Depends on lkvt_pkg.
interface lkvt_req_if;
	logic                               valid;
	logic                               ready;
	logic [lkvt_pkg::CMD_W-1:0]         command;
	logic [lkvt_pkg::KEY_W-1:0]         key;
	logic signed [lkvt_pkg::VAL_W-1:0]  value;

	modport source (output valid, command, key, value, input ready);
	modport sink   (input valid, command, key, value, output ready);
endinterface

@@ rtl/lkvt_rsp_if.sv @@
// Response channel: status, found value and entry count with valid/ready.
// Depends on lkvt_pkg.
interface lkvt_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [lkvt_pkg::STAT_W-1:0]        status;
	logic signed [lkvt_pkg::VAL_W-1:0]  found_value;
	logic [lkvt_pkg::ENTRY_W-1:0]       entry_count;

	modport source (output valid, status, found_value, entry_count, input ready);
	modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

@@ rtl/lkvt_ctrl.sv @@
// Sequencer of the key-value table: scan, lookup, update, insert, shift-delete.
// Depends on lkvt_pkg; drives lkvt_datapath through ctl_t.
module lkvt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  lkvt_pkg::sts_t   sts,
	output lkvt_pkg::ctl_t   ctl
);

	lkvt_pkg::state_t state_q;
	lkvt_pkg::state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkvt_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lkvt_pkg::S_IDLE: begin
				if (sts.in_valid) state_nxt = lkvt_pkg::S_SCAN;
			end
			lkvt_pkg::S_SCAN: begin
				state_nxt = sts.idx_end ? lkvt_pkg::S_FIN : lkvt_pkg::S_CMP;
			end
			lkvt_pkg::S_CMP: begin
				if (!sts.match) begin
					state_nxt = lkvt_pkg::S_SCAN;
				end else if (sts.cmd == lkvt_pkg::CMD_DELETE) begin
					state_nxt = lkvt_pkg::S_SHRD;
				end else begin
					state_nxt = lkvt_pkg::S_FIN;
				end
			end
			lkvt_pkg::S_SHRD: begin
				state_nxt = sts.shift_end ? lkvt_pkg::S_FIN : lkvt_pkg::S_SHWR;
			end
			lkvt_pkg::S_SHWR: begin
				state_nxt = lkvt_pkg::S_SHRD;
			end
			lkvt_pkg::S_FIN: begin
				if (sts.out_free) state_nxt = lkvt_pkg::S_IDLE;
			end
			default: state_nxt = lkvt_pkg::S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		ctl            = '0;
		ctl.addr_sel   = lkvt_pkg::ADDR_IDX;
		ctl.res_status = lkvt_pkg::ST_NOT_FOUND;
		unique case (state_q)
			lkvt_pkg::S_IDLE: begin
				ctl.in_ready = 1'b1;
			end
			lkvt_pkg::S_SCAN: begin
				if (sts.idx_end) begin
					// key absent
					ctl.res_load = 1'b1;
					if (sts.cmd == lkvt_pkg::CMD_WRITE) begin
						if (sts.full) begin
							ctl.res_status = lkvt_pkg::ST_FULL;
						end else begin
							ctl.wr_en      = 1'b1;
							ctl.addr_sel   = lkvt_pkg::ADDR_FILL;
							ctl.fill_inc   = 1'b1;
							ctl.res_status = lkvt_pkg::ST_INSERTED;
						end
					end
				end else begin
					ctl.rd_en = 1'b1;
				end
			end
			lkvt_pkg::S_CMP: begin
				if (!sts.match) begin
					ctl.idx_inc = 1'b1;
				end else if (sts.cmd == lkvt_pkg::CMD_WRITE) begin
					ctl.wr_en      = 1'b1;
					ctl.res_load   = 1'b1;
					ctl.res_status = lkvt_pkg::ST_UPDATED;
				end else if (sts.cmd != lkvt_pkg::CMD_DELETE) begin
					ctl.res_load   = 1'b1;
					ctl.res_found  = 1'b1;
					ctl.res_status = lkvt_pkg::ST_FOUND;
				end
			end
			lkvt_pkg::S_SHRD: begin
				if (sts.shift_end) begin
					ctl.fill_dec   = 1'b1;
					ctl.res_load   = 1'b1;
					ctl.res_status = lkvt_pkg::ST_DELETED;
				end else begin
					ctl.rd_en    = 1'b1;
					ctl.addr_sel = lkvt_pkg::ADDR_NEXT;
				end
			end
			lkvt_pkg::S_SHWR: begin
				// move entry idx+1 down into idx
				ctl.wr_en      = 1'b1;
				ctl.wd_from_rd = 1'b1;
				ctl.idx_inc    = 1'b1;
			end
			lkvt_pkg::S_FIN: begin
				ctl.out_load = sts.out_free;
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/lkvt_datapath.sv @@
// Datapath of the key-value table: entry memory, scan index, fill count,
// input, result and output registers. Depends on lkvt_pkg and the channel interfaces.
module lkvt_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  lkvt_pkg::ctl_t   ctl,
	output lkvt_pkg::sts_t   sts,
	lkvt_req_if.sink         req,
	lkvt_rsp_if.source       rsp
);

	lkvt_pkg::entry_t                  mem [lkvt_pkg::CAPACITY];
	lkvt_pkg::entry_t                  rd_q;
	logic [lkvt_pkg::CMD_W-1:0]        cmd_q;
	logic [lkvt_pkg::KEY_W-1:0]        key_q;
	logic signed [lkvt_pkg::VAL_W-1:0] val_q;
	logic [lkvt_pkg::CNT_W-1:0]        idx_q;
	logic [lkvt_pkg::CNT_W-1:0]        fill_q;
	logic [lkvt_pkg::CNT_W-1:0]        idx_next;
	lkvt_pkg::status_t                 res_status_q;
	logic signed [lkvt_pkg::VAL_W-1:0] res_found_q;
	logic                              out_valid_q;
	lkvt_pkg::status_t                 out_status_q;
	logic signed [lkvt_pkg::VAL_W-1:0] out_found_q;
	logic [lkvt_pkg::CNT_W-1:0]        out_count_q;
	logic [lkvt_pkg::ADDR_W-1:0]       addr;
	lkvt_pkg::entry_t                  wdata;
	logic                              accept;

	assign accept   = req.valid && req.ready;
	assign idx_next = idx_q + lkvt_pkg::CNT_W'(1);

	// Input beat capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.command;
			key_q <= req.key;
			val_q <= req.value;
		end
	end

	// Scan index and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			fill_q <= '0;
		end else begin
			if (accept) begin
				idx_q <= '0;
			end else if (ctl.idx_inc) begin
				idx_q <= idx_next;
			end
			if (ctl.fill_inc) begin
				fill_q <= fill_q + lkvt_pkg::CNT_W'(1);
			end else if (ctl.fill_dec) begin
				fill_q <= fill_q - lkvt_pkg::CNT_W'(1);
			end
		end
	end

	// Single-port memory address and write data
	always_comb begin
		case (ctl.addr_sel)
			lkvt_pkg::ADDR_NEXT: addr = idx_next[lkvt_pkg::ADDR_W-1:0];
			lkvt_pkg::ADDR_FILL: addr = fill_q[lkvt_pkg::ADDR_W-1:0];
			default:             addr = idx_q[lkvt_pkg::ADDR_W-1:0];
		endcase
		wdata.key   = key_q;
		wdata.value = val_q;
		if (ctl.wd_from_rd) wdata = rd_q;
	end

	// Entry memory, registered read
	always_ff @(posedge clk) begin
		if (ctl.wr_en) mem[addr] <= wdata;
		if (ctl.rd_en) rd_q <= mem[addr];
	end

	// Result of the item in flight
	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			res_status_q <= ctl.res_status;
			res_found_q  <= ctl.res_found ? rd_q.value : '0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_status_q <= res_status_q;
			out_found_q  <= res_found_q;
			out_count_q  <= fill_q;
		end
	end

	// Ports and status
	assign req.ready       = ctl.in_ready;
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.found_value = out_found_q;
	assign rsp.entry_count = lkvt_pkg::ENTRY_W'(out_count_q);

	assign sts.in_valid  = req.valid;
	assign sts.cmd       = cmd_q;
	assign sts.match     = (rd_q.key == key_q);
	assign sts.idx_end   = (idx_q == fill_q);
	assign sts.shift_end = (idx_next == fill_q);
	assign sts.full      = (fill_q == lkvt_pkg::CNT_W'(lkvt_pkg::CAPACITY));
	assign sts.out_free  = !out_valid_q || rsp.ready;

endmodule

@@ rtl/linear_key_value_table_top.sv @@
// Linear key-value table, up to 16 pairs in insertion order, one item at a time.
// Each entry is read through the single-port memory (S_SCAN) and then compared (S_CMP);
// a delete then shifts every later entry down by a read (S_SHRD) and a write (S_SHWR).
// A new request is taken only in S_IDLE, once the last item is through; the next beat
// is taken while a result waits, and a result that stays untaken stalls the next one.
// Reset (arst_n, async, active low) empties the table; stored entries are not cleared.
`include "linear_key_value_table_top_assert.svh"

module linear_key_value_table_top (
	input  logic        clk,
	input  logic        arst_n,
	lkvt_req_if.sink    req,
	lkvt_rsp_if.source  rsp
);

	lkvt_pkg::ctl_t ctl;
	lkvt_pkg::sts_t sts;

	lkvt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	lkvt_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

	// Checks
	`LKVT_ASSERT_NOW(a_count_range, clk, arst_n, rsp.valid, rsp.entry_count <= lkvt_pkg::ENTRY_W'(lkvt_pkg::CAPACITY))
	`LKVT_ASSERT_NOW(a_found_zero, clk, arst_n, rsp.valid && (rsp.status != lkvt_pkg::ST_FOUND), rsp.found_value == '0)
	`LKVT_ASSERT_NOW(a_port_excl, clk, arst_n, ctl.wr_en, !ctl.rd_en)
	`LKVT_ASSERT_NEXT(a_one_item, clk, arst_n, req.valid && req.ready, !req.ready)

endmodule
